@@ hdl/depth_pixel_backprojection_masked_defines.svh @@
// Assertion macros for the masked depth back-projection block.
// Plain text macros, no other dependencies; define ASSERT_OFF to drop the checks.
`ifndef DEPTH_PIXEL_BACKPROJECTION_MASKED_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_MASKED_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define DPBM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dpbm: same-cycle check failed");
// next-cycle implication
`define DPBM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpbm: next-cycle check failed");
`else
`define DPBM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DPBM_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ hdl/dpbm_pkg.sv @@
// Shared types and constants for the masked depth back-projection block.
// No dependencies.
package dpbm_pkg;

  // parameter defaults
  localparam int REGIONS_DEF       = 4;
  localparam int MAX_COLS_DEF      = 2048;
  localparam int SAMPLE_STRIDE_DEF = 3;

  // item opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_CENTER_X     = 3'd0;
  localparam logic [2:0] REG_CENTER_Y     = 3'd1;
  localparam logic [2:0] REG_INV_FOCAL_X  = 3'd2;
  localparam logic [2:0] REG_INV_FOCAL_Y  = 3'd3;
  localparam logic [2:0] REG_REGION_COUNT = 3'd4;
  localparam logic [2:0] REG_MIN_DEPTH    = 3'd5;
  localparam logic [2:0] REG_MAX_DEPTH    = 3'd6;
  localparam logic [2:0] REG_DEPTH_MARGIN = 3'd7;

  // reset values
  localparam logic [15:0] MIN_DEPTH_RST    = 16'd10;
  localparam logic [15:0] MAX_DEPTH_RST    = 16'd10000;
  localparam logic [15:0] DEPTH_MARGIN_RST = 16'd1000;

  // rounding / saturation of the Q.28 product
  localparam int          FRAC_BITS   = 28;
  localparam logic [27:0] SAT_POS_MAG = 28'd8388607;
  localparam logic [27:0] SAT_NEG_MAG = 28'd8388608;
  localparam logic [23:0] SAT_POS     = 24'h7FFFFF;
  localparam logic [23:0] SAT_NEG     = 24'h800000;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  region_index;
    logic [10:0] col;
    logic [10:0] row;
    logic [11:0] width;
    logic [11:0] height;
    logic [15:0] depth;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_req_t;

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic [15:0]        point_z;
    logic [7:0]         point_red;
    logic [7:0]         point_green;
    logic [7:0]         point_blue;
  } point_t;

  typedef struct packed {
    logic [2:0]  addr;
    logic [23:0] wdata;
  } cfg_req_t;

  typedef struct packed {
    logic [10:0] left;
    logic [10:0] top;
    logic [11:0] width;
    logic [11:0] height;
    logic [15:0] ref_depth;
  } region_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

@@ hdl/dpbm_stream_if.sv @@
// Valid/ready request channel with a typed payload.
// Used for the pixel, point and configuration channels; no dependencies.
interface dpbm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/depth_pixel_backprojection_masked.sv @@
// Masked pinhole back-projection of depth pixels: top level.
// Depends on dpbm_pkg, dpbm_stream_if and depth_pixel_backprojection_masked_defines.svh.
//
// Throughput is one request per clock when the pipe is not backed up: pixels and region
// loads enter back to back, and a kept pixel passes five register stages (check, |d|*z,
// *1/f, round, output). Backpressure runs stage by stage, so bubbles are squeezed out and
// the input stays ready as long as some stage is empty, even while the output holds a
// result nobody has taken yet; with all five stages full and the output stalled, the
// input drops ready. Pixels off the sampling grid, outside [min_depth, max_depth], past
// MAX_COLS, or masked by a dynamic rectangle produce nothing; region loads produce
// nothing either. The region table sits in flip-flops and clears in the reset cycle
// itself, so there is no clearing pass. Config writes are taken every cycle (ready tied
// high) and must only be issued while the pipe is empty.
`include "depth_pixel_backprojection_masked_defines.svh"

module depth_pixel_backprojection_masked
  import dpbm_pkg::*;
#(
  parameter int REGIONS       = REGIONS_DEF,
  parameter int MAX_COLS      = MAX_COLS_DEF,
  parameter int SAMPLE_STRIDE = SAMPLE_STRIDE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  dpbm_stream_if.sink   cfg,
  dpbm_stream_if.sink   pixel_in,
  dpbm_stream_if.source point_out
);

  // Grid test: x is a multiple of S iff floor(x*R >> 24)*S == x, R = ceil(2^24/S).
  // The error term of R is below S, far too small to disturb 11-bit inputs.
  localparam int STRIDE_SHIFT = 24;
  localparam int STRIDE_RECIP = ((1 << STRIDE_SHIFT) + SAMPLE_STRIDE - 1) / SAMPLE_STRIDE;
  localparam int GRID_PROD_W  = 11 + STRIDE_SHIFT + 1;
  localparam int GRID_Q_W     = GRID_PROD_W - STRIDE_SHIFT;
  localparam int GRID_BACK_W  = GRID_Q_W + 4;

  // ---------------- configuration registers ----------------
  logic [14:0] center_x;
  logic [14:0] center_y;
  logic [23:0] inv_focal_x;
  logic [23:0] inv_focal_y;
  logic [2:0]  region_count;
  logic [15:0] min_depth;
  logic [15:0] max_depth;
  logic [15:0] depth_margin;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      inv_focal_x  <= '0;
      inv_focal_y  <= '0;
      region_count <= '0;
      min_depth    <= MIN_DEPTH_RST;
      max_depth    <= MAX_DEPTH_RST;
      depth_margin <= DEPTH_MARGIN_RST;
    end else if (cfg.valid) begin
      case (cfg.data.addr)
        REG_CENTER_X:     center_x     <= cfg.data.wdata[14:0];
        REG_CENTER_Y:     center_y     <= cfg.data.wdata[14:0];
        REG_INV_FOCAL_X:  inv_focal_x  <= cfg.data.wdata;
        REG_INV_FOCAL_Y:  inv_focal_y  <= cfg.data.wdata;
        REG_REGION_COUNT: region_count <= cfg.data.wdata[2:0];
        REG_MIN_DEPTH:    min_depth    <= cfg.data.wdata[15:0];
        REG_MAX_DEPTH:    max_depth    <= cfg.data.wdata[15:0];
        REG_DEPTH_MARGIN: depth_margin <= cfg.data.wdata[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // Each stage takes new data when it is empty or the one after it moves.
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

  assign s5_ready = !s5_valid || point_out.ready;
  assign s4_ready = !s4_valid || s5_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;

  assign pixel_in.ready = s1_ready;

  // ---------------- stage 1: input register, filters, offsets ----------------
  pixel_req_t s1_item;
  region_t    regions [REGIONS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pixel_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && pixel_in.valid) begin
      s1_item <= pixel_in.data;
    end
  end

  // Loads hit the table as they leave stage 1, so every pixel is checked
  // against exactly the loads that came before it.
  logic load_fire;
  assign load_fire = s1_valid && s2_ready && (s1_item.opcode == OP_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < REGIONS; k++) begin
        regions[k] <= '0;
      end
    end else if (load_fire) begin
      for (int k = 0; k < REGIONS; k++) begin
        if (32'(s1_item.region_index) == k) begin
          regions[k] <= '{left:      s1_item.col,
                          top:       s1_item.row,
                          width:     s1_item.width,
                          height:    s1_item.height,
                          ref_depth: s1_item.depth};
        end
      end
    end
  end

  // sampling grid
  logic [GRID_PROD_W-1:0] col_prod, row_prod;
  logic [GRID_BACK_W-1:0] col_back, row_back;
  logic                   on_grid;

  assign col_prod = GRID_PROD_W'(s1_item.col) * GRID_PROD_W'(STRIDE_RECIP);
  assign row_prod = GRID_PROD_W'(s1_item.row) * GRID_PROD_W'(STRIDE_RECIP);
  assign col_back = GRID_BACK_W'(col_prod[GRID_PROD_W-1:STRIDE_SHIFT])
                    * GRID_BACK_W'(SAMPLE_STRIDE);
  assign row_back = GRID_BACK_W'(row_prod[GRID_PROD_W-1:STRIDE_SHIFT])
                    * GRID_BACK_W'(SAMPLE_STRIDE);
  assign on_grid  = (col_back == GRID_BACK_W'(s1_item.col))
                 && (row_back == GRID_BACK_W'(s1_item.row));

  logic col_in_range, depth_ok;
  assign col_in_range = 13'(s1_item.col) < 13'(MAX_COLS);
  assign depth_ok     = (s1_item.depth >= min_depth) && (s1_item.depth <= max_depth);

  // dynamic rectangles, all checked in parallel
  logic masked;
  always_comb begin
    logic [12:0] right_edge;
    logic [12:0] bottom_edge;
    logic        in_rect;
    logic        too_close;
    masked = 1'b0;
    for (int k = 0; k < REGIONS; k++) begin
      right_edge  = 13'(regions[k].left) + 13'(regions[k].width);
      bottom_edge = 13'(regions[k].top) + 13'(regions[k].height);
      in_rect     = (s1_item.col >= regions[k].left)
                 && (13'(s1_item.col) < right_edge)
                 && (s1_item.row >= regions[k].top)
                 && (13'(s1_item.row) < bottom_edge);
      // depth - ref < margin, kept unsigned
      too_close   = 17'(s1_item.depth) < (17'(regions[k].ref_depth) + 17'(depth_margin));
      if ((32'(region_count) > k) && in_rect && too_close) begin
        masked = 1'b1;
      end
    end
  end

  logic keep1;
  assign keep1 = (s1_item.opcode == OP_PIXEL) && on_grid && col_in_range
              && depth_ok && !masked;

  // signed Q.4 offsets from the principal point
  logic signed [16:0] dx1, dy1;
  assign dx1 = $signed({2'b00, s1_item.col, 4'b0000}) - $signed({2'b00, center_x});
  assign dy1 = $signed({2'b00, s1_item.row, 4'b0000}) - $signed({2'b00, center_y});

  // ---------------- stage 2: |d| * z ----------------
  logic signed [16:0] s2_dx, s2_dy;
  logic [15:0]        s2_depth;
  rgb_t               s2_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid && keep1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_dx    <= dx1;
      s2_dy    <= dy1;
      s2_depth <= s1_item.depth;
      s2_rgb   <= '{red: s1_item.red, green: s1_item.green, blue: s1_item.blue};
    end
  end

  // |d| never exceeds 32767, so 15 bits carry it
  logic [16:0] abs_x, abs_y;
  logic [30:0] prod_xz, prod_yz;
  assign abs_x   = s2_dx[16] ? 17'(-s2_dx) : 17'(s2_dx);
  assign abs_y   = s2_dy[16] ? 17'(-s2_dy) : 17'(s2_dy);
  assign prod_xz = 31'(abs_x[14:0]) * 31'(s2_depth);
  assign prod_yz = 31'(abs_y[14:0]) * 31'(s2_depth);

  // ---------------- stage 3: * 1/f ----------------
  logic [30:0] s3_xz, s3_yz;
  logic        s3_neg_x, s3_neg_y;
  logic [15:0] s3_depth;
  rgb_t        s3_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_xz    <= prod_xz;
      s3_yz    <= prod_yz;
      s3_neg_x <= s2_dx[16];
      s3_neg_y <= s2_dy[16];
      s3_depth <= s2_depth;
      s3_rgb   <= s2_rgb;
    end
  end

  logic [54:0] prod_x, prod_y;
  assign prod_x = 55'(s3_xz) * 55'(inv_focal_x);
  assign prod_y = 55'(s3_yz) * 55'(inv_focal_y);

  // ---------------- stage 4: round and saturate ----------------
  logic [54:0] s4_px, s4_py;
  logic        s4_neg_x, s4_neg_y;
  logic [15:0] s4_depth;
  rgb_t        s4_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_ready) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_px    <= prod_x;
      s4_py    <= prod_y;
      s4_neg_x <= s3_neg_x;
      s4_neg_y <= s3_neg_y;
      s4_depth <= s3_depth;
      s4_rgb   <= s3_rgb;
    end
  end

  // round half away from zero on the magnitude, then reapply sign and clamp
  function automatic logic [23:0] round_sat(input logic [54:0] p, input logic neg);
    logic [55:0] sum;
    logic [27:0] mag;
    logic [23:0] res;
    sum = 56'(p) + (56'(1) << (FRAC_BITS - 1));
    mag = sum[55:FRAC_BITS];
    if (neg) begin
      res = (mag > SAT_NEG_MAG) ? SAT_NEG : 24'(28'(0) - mag);
    end else begin
      res = (mag > SAT_POS_MAG) ? SAT_POS : mag[23:0];
    end
    return res;
  endfunction

  point_t point4;
  always_comb begin
    point4.point_x     = $signed(round_sat(s4_px, s4_neg_x));
    point4.point_y     = $signed(round_sat(s4_py, s4_neg_y));
    point4.point_z     = s4_depth;
    point4.point_red   = s4_rgb.red;
    point4.point_green = s4_rgb.green;
    point4.point_blue  = s4_rgb.blue;
  end

  // ---------------- stage 5: output register ----------------
  point_t s5_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (s5_ready) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_ready) begin
      s5_point <= point4;
    end
  end

  assign point_out.valid = s5_valid;
  assign point_out.data  = s5_point;

  // ---------------- checks ----------------
  logic s5_in_window;
  assign s5_in_window = (s5_point.point_z >= min_depth) && (s5_point.point_z <= max_depth);

  // a taken request always lands in stage 1
  `DPBM_ASSERT_NXT(a_accept_lands, clk, rst, pixel_in.valid && s1_ready, s1_valid)
  // a region load never turns into a point
  `DPBM_ASSERT_NXT(a_load_no_point, clk, rst, load_fire, !s2_valid)
  // every delivered point passed the depth window
  `DPBM_ASSERT_IMP(a_depth_window, clk, rst, s5_valid, s5_in_window)

endmodule

@@ tb/tb_depth_pixel_backprojection_masked.sv @@
// Self-checking testbench for the masked depth back-projection block.
// Depends on dpbm_pkg, dpbm_stream_if and the depth_pixel_backprojection_masked top level.
module tb_depth_pixel_backprojection_masked import dpbm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Pipe is five register stages deep; settle a bit longer before touching config.
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 200000;

  // Scoreboard: keeps its own copy of the register file and the region table,
  // predicts the point for each accepted pixel request, and checks outputs in order.
  class point_scoreboard;
    point_t      expected_q[$];
    region_t     regions[REGIONS_DEF];
    logic [14:0] center_x, center_y;
    logic [23:0] inv_focal_x, inv_focal_y;
    logic [2:0]  region_count;
    logic [15:0] min_depth, max_depth, depth_margin;
    int          errors;

    function new();
      foreach (regions[k]) regions[k] = '0;
      center_x     = '0;
      center_y     = '0;
      inv_focal_x  = '0;
      inv_focal_y  = '0;
      region_count = '0;
      min_depth    = MIN_DEPTH_RST;
      max_depth    = MAX_DEPTH_RST;
      depth_margin = DEPTH_MARGIN_RST;
      errors       = 0;
    endfunction

    function void write_reg(logic [2:0] addr, logic [23:0] value);
      case (addr)
        REG_CENTER_X:     center_x     = value[14:0];
        REG_CENTER_Y:     center_y     = value[14:0];
        REG_INV_FOCAL_X:  inv_focal_x  = value;
        REG_INV_FOCAL_Y:  inv_focal_y  = value;
        REG_REGION_COUNT: region_count = value[2:0];
        REG_MIN_DEPTH:    min_depth    = value[15:0];
        REG_MAX_DEPTH:    max_depth    = value[15:0];
        REG_DEPTH_MARGIN: depth_margin = value[15:0];
        default: ;
      endcase
    endfunction

    // (pos*16 - center) * z * inv_f in Q.28, rounded half away from zero, saturated to 24 bits
    static function logic [23:0] back_project(logic [10:0] pos, logic [14:0] center,
                                              logic [23:0] inv_f, logic [15:0] z);
      longint          offset, ctr;
      longint unsigned mag, prod, rounded, negated;
      bit              neg;
      offset  = longint'(pos);
      ctr     = longint'(center);
      offset  = offset * 16 - ctr;
      neg     = (offset < 0);
      mag     = neg ? -offset : offset;
      prod    = mag * z * inv_f;
      rounded = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (neg) begin
        if (rounded > SAT_NEG_MAG) return SAT_NEG;
        negated = 64'd0 - rounded;
        return negated[23:0];
      end
      if (rounded > SAT_POS_MAG) return SAT_POS;
      return rounded[23:0];
    endfunction

    function void note_request(pixel_req_t p);
      int      lim, k, err;
      region_t r;
      point_t  pt;
      if (p.opcode == OP_LOAD) begin
        regions[p.region_index] = '{left: p.col, top: p.row, width: p.width,
                                    height: p.height, ref_depth: p.depth};
        return;
      end
      if (p.col % SAMPLE_STRIDE_DEF != 0 || p.row % SAMPLE_STRIDE_DEF != 0) return;
      if (p.col >= MAX_COLS_DEF) return;
      if (p.depth < min_depth || p.depth > max_depth) return;
      lim = (int'(region_count) > REGIONS_DEF) ? REGIONS_DEF : int'(region_count);
      for (k = 0; k < lim; k++) begin
        r   = regions[k];
        err = int'(p.depth) - int'(r.ref_depth);
        if (p.col >= r.left && int'(p.col) < int'(r.left) + int'(r.width) &&
            p.row >= r.top && int'(p.row) < int'(r.top) + int'(r.height) &&
            err < int'(depth_margin))
          return;
      end
      pt.point_x     = back_project(p.col, center_x, inv_focal_x, p.depth);
      pt.point_y     = back_project(p.row, center_y, inv_focal_y, p.depth);
      pt.point_z     = p.depth;
      pt.point_red   = p.red;
      pt.point_green = p.green;
      pt.point_blue  = p.blue;
      expected_q = {expected_q, pt};
    endfunction

    function void check_point(point_t got);
      point_t want;
      string  want_s, got_s;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected point: x=%0d y=%0d z=%0d rgb=%0d/%0d/%0d",
                   got.point_x, got.point_y, got.point_z,
                   got.point_red, got.point_green, got.point_blue);
        return;
      end
      want = expected_q.pop_front();
      if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
          got.point_z !== want.point_z || got.point_red !== want.point_red ||
          got.point_green !== want.point_green || got.point_blue !== want.point_blue) begin
        errors++;
        if (errors <= 10) begin
          want_s = $sformatf("x=%0d y=%0d z=%0d rgb=%0d/%0d/%0d",
                             want.point_x, want.point_y, want.point_z,
                             want.point_red, want.point_green, want.point_blue);
          got_s  = $sformatf("x=%0d y=%0d z=%0d rgb=%0d/%0d/%0d",
                             got.point_x, got.point_y, got.point_z,
                             got.point_red, got.point_green, got.point_blue);
          $display("point mismatch: expected %s, got %s", want_s, got_s);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  dpbm_stream_if #(.payload_t(cfg_req_t))   cfg_if ();
  dpbm_stream_if #(.payload_t(pixel_req_t)) pixel_if ();
  dpbm_stream_if #(.payload_t(point_t))     point_if ();

  depth_pixel_backprojection_masked u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_if),
    .pixel_in  (pixel_if),
    .point_out (point_if)
  );

  point_scoreboard sb = new();

  // idle-mode flags: when set, that side runs back to back for a stretch
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int rx_hold = 0;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung pipe or a lost point ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** depth_pixel_backprojection_masked: FAILED **");
      $finish;
    end
  end

  // Point sink: check every accepted point, then stall for a random number of cycles.
  // Signals are read right after the edge, so they hold their pre-edge values.
  always @(posedge clk) begin
    if (!rst) begin
      if (point_if.valid && point_if.ready) begin
        sb.check_point(point_if.data);
        if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
        rx_hold = rx_calm ? 0 : $urandom_range(0, 10);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      point_if.ready <= (rx_hold == 0);
    end
  end

  // One config write; valid stays up so back-to-back writes need no re-raise.
  // Bits above the register width get random junk, which the block must mask.
  task automatic cfg_write(input logic [2:0] addr, input logic [23:0] value, input int bits);
    logic [23:0] noise;
    logic [23:0] wdata;
    noise = 24'($urandom());
    wdata = value | (noise << bits);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{addr: addr, wdata: wdata};
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(addr, wdata);
  endtask

  task automatic program_regs(input logic [23:0] cx, input logic [23:0] cy,
                              input logic [23:0] ifx, input logic [23:0] ify,
                              input logic [23:0] count, input logic [23:0] dmin,
                              input logic [23:0] dmax, input logic [23:0] margin);
    cfg_write(REG_CENTER_X, cx, 15);
    cfg_write(REG_CENTER_Y, cy, 15);
    cfg_write(REG_INV_FOCAL_X, ifx, 24);
    cfg_write(REG_INV_FOCAL_Y, ify, 24);
    cfg_write(REG_REGION_COUNT, count, 3);
    cfg_write(REG_MIN_DEPTH, dmin, 16);
    cfg_write(REG_MAX_DEPTH, dmax, 16);
    cfg_write(REG_DEPTH_MARGIN, margin, 16);
    cfg_if.valid <= 1'b0;
  endtask

  // Send one request after a random gap; valid is held high across back-to-back requests.
  task automatic send_item(input pixel_req_t p);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      pixel_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_if.valid <= 1'b1;
    pixel_if.data  <= p;
    do @(posedge clk); while (!pixel_if.ready);
    sb.note_request(p);
  endtask

  // Stop sending until every predicted point is back, then let dropped
  // pixels still in flight drain out of the pipe.
  task automatic wait_for_points();
    pixel_if.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pixel request; the load-only fields carry random junk.
  function automatic pixel_req_t make_pixel(logic [10:0] col, logic [10:0] row,
                                            logic [15:0] depth, logic [7:0] red,
                                            logic [7:0] green, logic [7:0] blue);
    pixel_req_t p;
    p.opcode       = OP_PIXEL;
    p.region_index = 2'($urandom_range(0, 3));
    p.col          = col;
    p.row          = row;
    p.width        = 12'($urandom_range(0, 4095));
    p.height       = 12'($urandom_range(0, 4095));
    p.depth        = depth;
    p.red          = red;
    p.green        = green;
    p.blue         = blue;
    return p;
  endfunction

  // Region load; the color fields carry random junk.
  function automatic pixel_req_t make_load(logic [1:0] slot, logic [10:0] left,
                                           logic [10:0] top, logic [11:0] w,
                                           logic [11:0] h, logic [15:0] ref_depth);
    pixel_req_t p;
    p.opcode       = OP_LOAD;
    p.region_index = slot;
    p.col          = left;
    p.row          = top;
    p.width        = w;
    p.height       = h;
    p.depth        = ref_depth;
    p.red          = 8'($urandom_range(0, 255));
    p.green        = 8'($urandom_range(0, 255));
    p.blue         = 8'($urandom_range(0, 255));
    return p;
  endfunction

  function automatic logic [15:0] clamp_depth(int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // Mostly inside the accepted depth window, with hits on both window edges.
  function automatic logic [15:0] pick_depth();
    int lo, hi, roll;
    lo   = int'(sb.min_depth);
    hi   = int'(sb.max_depth);
    roll = $urandom_range(0, 99);
    if (roll < 70 && lo <= hi) return 16'($urandom_range(lo, hi));
    if (roll < 80) return clamp_depth(lo + int'($urandom_range(0, 4)) - 2);
    if (roll < 90) return clamp_depth(hi + int'($urandom_range(0, 4)) - 2);
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic int on_grid();
    return (SAMPLE_STRIDE_DEF * $urandom_range(0, (MAX_COLS_DEF - 1) / SAMPLE_STRIDE_DEF));
  endfunction

  // Random mix: some region loads, many pixels aimed into a loaded rectangle with
  // depth near the masking threshold, the rest spread over the frame.
  function automatic pixel_req_t random_item();
    int      roll, k, c, r, d;
    region_t slot_entry;
    roll = $urandom_range(0, 99);
    if (roll < 12)
      return make_load(2'($urandom_range(0, 3)), 11'($urandom_range(0, 2047)),
                       11'($urandom_range(0, 2047)),
                       12'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2048)
                                                       : $urandom_range(1, 700)),
                       12'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2048)
                                                       : $urandom_range(1, 700)),
                       16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 8000)));
    if (roll < 40) begin
      k          = $urandom_range(0, REGIONS_DEF - 1);
      slot_entry = sb.regions[k];
      c = slot_entry.left + ((slot_entry.width > 0) ? $urandom_range(0, slot_entry.width - 1) : 0);
      r = slot_entry.top + ((slot_entry.height > 0) ? $urandom_range(0, slot_entry.height - 1) : 0);
      if (c > 2047) c = 2047;
      if (r > 2047) r = 2047;
      c = c - c % SAMPLE_STRIDE_DEF;
      r = r - r % SAMPLE_STRIDE_DEF;
      if ($urandom_range(0, 1) == 0)
        d = int'(slot_entry.ref_depth) + int'(sb.depth_margin) + int'($urandom_range(0, 6)) - 3;
      else
        d = int'(pick_depth());
      return make_pixel(11'(c), 11'(r), clamp_depth(d), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    c = ($urandom_range(0, 9) < 7) ? on_grid() : $urandom_range(0, 2047);
    r = ($urandom_range(0, 9) < 7) ? on_grid() : $urandom_range(0, 2047);
    return make_pixel(11'(c), 11'(r), pick_depth(), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  task automatic run_random(input int count);
    repeat (count) begin
      send_item(random_item());
      // now and then hold off until the pipe is empty mid-phase
      if ($urandom_range(0, 149) == 0) wait_for_points();
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    pixel_if.valid = 1'b0;
    pixel_if.data  = '0;
    point_if.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: zero reciprocals give x = y = 0, depth window 10..10000.
    send_item(make_pixel(0, 0, 16'd10, 8'd0, 8'd0, 8'd0));
    send_item(make_pixel(2046, 2046, 16'd10000, 8'd255, 8'd255, 8'd255));
    send_item(make_pixel(3, 3, 16'd9, 8'd1, 8'd2, 8'd3));        // below window
    send_item(make_pixel(3, 3, 16'd10001, 8'd1, 8'd2, 8'd3));    // above window
    send_item(make_pixel(2047, 0, 16'd100, 8'd4, 8'd5, 8'd6));   // column off grid
    send_item(make_pixel(0, 1, 16'd100, 8'd4, 8'd5, 8'd6));      // row off grid
    wait_for_points();

    // Typical camera, full depth window, all four rectangles active.
    program_regs(24'd5120, 24'd3840, 24'd31957, 24'd31957, 24'd4, 24'd0, 24'd65535, 24'd1000);
    send_item(make_load(2'd0, 11'd100, 11'd100, 12'd50, 12'd50, 16'd2000));
    send_item(make_load(2'd1, 11'd0, 11'd0, 12'd0, 12'd2048, 16'd0));         // zero width
    send_item(make_load(2'd2, 11'd2047, 11'd2047, 12'd2048, 12'd2048, 16'hFFFF));
    send_item(make_load(2'd3, 11'd300, 11'd300, 12'd1, 12'd1, 16'd500));      // single pixel
    send_item(make_pixel(102, 102, 16'd2999, 8'd10, 8'd20, 8'd30)); // just under margin
    send_item(make_pixel(102, 102, 16'd3000, 8'd10, 8'd20, 8'd30)); // exactly at margin
    send_item(make_pixel(102, 102, 16'd1000, 8'd10, 8'd20, 8'd30)); // closer than region
    send_item(make_pixel(150, 150, 16'd2000, 8'd11, 8'd22, 8'd33)); // right/bottom edge excluded
    send_item(make_pixel(99, 99, 16'd2000, 8'd11, 8'd22, 8'd33));   // left/top of region
    send_item(make_pixel(0, 0, 16'd5, 8'd0, 8'd255, 8'd0));         // zero-width rectangle
    send_item(make_pixel(300, 300, 16'd1499, 8'd1, 8'd1, 8'd1));    // masked by one-pixel region
    send_item(make_pixel(300, 300, 16'hFFFF, 8'd1, 8'd1, 8'd1));
    send_item(make_pixel(2046, 2046, 16'hFFFF, 8'd255, 8'd0, 8'd255));
    send_item(make_pixel(2046, 0, 16'd0, 8'd7, 8'd8, 8'd9));        // zero depth, negative y offset
    wait_for_points();

    // Phase 1: typical intrinsics.
    program_regs(24'd5120, 24'd3840, 24'd31957, 24'd31957, 24'd4, 24'd10, 24'd10000, 24'd1000);
    run_random(130);
    wait_for_points();

    // Phase 2: extreme center and reciprocals drive saturation; count above the table size.
    program_regs(24'd32767, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd7, 24'd0, 24'd65535, 24'd0);
    run_random(130);
    wait_for_points();

    // Phase 3: min above max, so every pixel is dropped.
    program_regs(24'd0, 24'd32767, 24'd0, 24'h123456, 24'd2, 24'd500, 24'd400, 24'd300);
    run_random(50);
    wait_for_points();

    // Phase 4: random intrinsics, widest margin masks almost everything inside a rectangle.
    program_regs(24'($urandom_range(0, 32767)), 24'($urandom_range(0, 32767)),
                 24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                 24'd5, 24'd100, 24'd3000, 24'd65535);
    run_random(150);
    wait_for_points();

    // Phase 5: a single accepted depth, one active rectangle.
    begin
      logic [15:0] only_depth;
      only_depth = 16'($urandom_range(0, 65535));
      program_regs(24'd16000, 24'd16000, 24'($urandom_range(1, 24'hFFFFFF)),
                   24'($urandom_range(1, 24'hFFFFFF)), 24'd1, 24'(only_depth),
                   24'(only_depth), 24'd500);
    end
    run_random(140);
    wait_for_points();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** depth_pixel_backprojection_masked: PASSED **");
    end else begin
      $display("** depth_pixel_backprojection_masked: FAILED **");
    end
    $finish;
  end

endmodule
